### rtl/tccs_pkg.sv
`timescale 1ns / 1ps

package tccs_pkg;

   // screen geometry
   localparam int COLUMNS       = 80;
   localparam int ROWS          = 25;
   localparam int DEF_TAB_WIDTH = 8;
   localparam int CELL_COUNT    = COLUMNS * ROWS;

   localparam int ADDR_W = 11;
   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;
   localparam int ATTR_W = 8;
   localparam int CHAR_W = 8;
   localparam int CELL_W = ATTR_W + CHAR_W;

   localparam int CMD_DEPTH = 2;
   localparam int RSP_DEPTH = 2;

   // request codes
   localparam logic [1:0] REQ_PUT   = 2'd0;
   localparam logic [1:0] REQ_CLEAR = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;

   // character codes
   localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_DEL   = 8'h7F;

   localparam logic [ATTR_W-1:0] RESET_ATTR  = 8'h0F;
   localparam logic [CELL_W-1:0] RESET_BLANK = {RESET_ATTR, CH_SPACE};

   typedef enum logic [2:0] {
      BK_INIT,
      BK_IDLE,
      BK_READ_WAIT,
      BK_COPY,
      BK_BLANK
   } back_state_type;

   // classified request handed from front to back
   typedef struct packed {
      logic              do_write;
      logic              do_scroll;
      logic              do_clear;
      logic              do_read;
      logic              rd_valid;
      logic [ADDR_W-1:0] addr;
      logic [CELL_W-1:0] wdata;
      logic [ATTR_W-1:0] attr;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [ADDR_W-1:0] pos;
   } cmd_type;

   typedef struct packed {
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [ADDR_W-1:0] pos;
      logic              did_scroll;
      logic [CELL_W-1:0] cell_data;
   } rsp_type;

endpackage

### rtl/tccs_fifo.sv
`timescale 1ns / 1ps

module tccs_fifo
   import tccs_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);

   localparam int PtrW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CntW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

### rtl/tccs_front.sv
`timescale 1ns / 1ps

module tccs_front
   import tccs_pkg::*;
#(
   parameter int TAB_WIDTH = DEF_TAB_WIDTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [1:0]        req_type,
   input  logic [CHAR_W-1:0] req_char_code,
   input  logic [ADDR_W-1:0] req_cell_index,
   input  logic              csr_wr_en,
   input  logic [ATTR_W-1:0] csr_wr_data,
   input  logic              init_busy,
   input  logic              cmd_full,
   output logic              cmd_push,
   output cmd_type           cmd
);

   localparam int ColXW = $clog2(COLUMNS + TAB_WIDTH);
   localparam int RowXW = ROW_W + 1;

   typedef logic [ColXW-1:0] tab_tbl_type [COLUMNS];

   // next tab stop for every column, built with a running stop
   function automatic tab_tbl_type build_tab_tbl();
      tab_tbl_type tbl;
      int stop;
      stop = TAB_WIDTH;
      for (int c = 0; c < COLUMNS; c++) begin
         if (c >= stop) begin
            stop = stop + TAB_WIDTH;
         end
         tbl[c] = ColXW'(stop);
      end
      return tbl;
   endfunction

   localparam tab_tbl_type TabTbl = build_tab_tbl();

   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [ATTR_W-1:0] attr_ff;
   logic [ColXW-1:0]  col_x;
   logic [RowXW-1:0]  row_x;
   logic              put_wr;
   logic              put_scroll;
   logic [ADDR_W-1:0] cur_pos;
   logic              accept;

   assign full     = cmd_full || init_busy;
   assign accept   = push && !full;
   assign cmd_push = accept;
   assign cur_pos  = ADDR_W'(row_ff) * ADDR_W'(COLUMNS) + ADDR_W'(col_ff);

   // cursor motion of a put request
   always_comb begin
      col_x      = ColXW'(col_ff);
      row_x      = RowXW'(row_ff);
      put_wr     = 1'b0;
      put_scroll = 1'b0;
      case (req_char_code)
         CH_BS: begin
            if (col_ff != '0) begin
               col_x = col_x - ColXW'(1);
            end
         end
         CH_TAB: begin
            col_x = TabTbl[col_ff];
         end
         CH_CR: begin
            col_x = '0;
         end
         CH_LF: begin
            col_x = '0;
            row_x = row_x + RowXW'(1);
         end
         default: begin
            if (req_char_code inside {[CH_SPACE:CH_DEL]}) begin
               put_wr = 1'b1;
               col_x  = col_x + ColXW'(1);
            end
         end
      endcase
      if (col_x >= ColXW'(COLUMNS)) begin
         col_x = '0;
         row_x = row_x + RowXW'(1);
      end
      if (row_x >= RowXW'(ROWS)) begin
         row_x      = RowXW'(ROWS - 1);
         put_scroll = 1'b1;
      end
   end

   always_comb begin
      cmd.do_write  = 1'b0;
      cmd.do_scroll = 1'b0;
      cmd.do_clear  = 1'b0;
      cmd.do_read   = 1'b0;
      cmd.rd_valid  = 1'b0;
      cmd.addr      = cur_pos;
      cmd.wdata     = {attr_ff, req_char_code};
      cmd.attr      = attr_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      case (req_type)
         REQ_PUT: begin
            cmd.do_write  = put_wr;
            cmd.do_scroll = put_scroll;
            col_in        = COL_W'(col_x);
            row_in        = ROW_W'(row_x);
         end
         REQ_CLEAR: begin
            cmd.do_clear = 1'b1;
            col_in       = '0;
            row_in       = '0;
         end
         REQ_READ: begin
            cmd.do_read  = 1'b1;
            cmd.rd_valid = (req_cell_index < ADDR_W'(CELL_COUNT));
            cmd.addr     = req_cell_index;
         end
         default: begin
         end
      endcase
      cmd.row = row_in;
      cmd.col = col_in;
      cmd.pos = ADDR_W'(row_in) * ADDR_W'(COLUMNS) + ADDR_W'(col_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         attr_ff <= RESET_ATTR;
      end else begin
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (csr_wr_en) begin
            attr_ff <= csr_wr_data;
         end
      end
   end

   cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      (col_ff < COL_W'(COLUMNS)) && (row_ff < ROW_W'(ROWS)))
      else $error("cursor outside the screen");

   no_accept_in_init: assert property (@(posedge clock) disable iff (reset)
      init_busy |-> !cmd_push)
      else $error("item accepted during clearing pass");

   pos_on_screen: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> (cmd.pos < ADDR_W'(CELL_COUNT)))
      else $error("cursor position past the last cell");

endmodule

### rtl/tccs_back.sv
`timescale 1ns / 1ps

module tccs_back
   import tccs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_empty,
   input  cmd_type cmd,
   output logic    cmd_pop,
   input  logic    rsp_full,
   output logic    rsp_push,
   output rsp_type rsp,
   output logic    init_busy
);

   localparam logic [ADDR_W-1:0] CopyEnd  = ADDR_W'((ROWS - 1) * COLUMNS);
   localparam logic [ADDR_W-1:0] LastCell = ADDR_W'(CELL_COUNT - 1);

   logic [CELL_W-1:0] cells_mem [CELL_COUNT];
   logic [CELL_W-1:0] rd_data_ff;

   back_state_type    state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [ADDR_W-1:0] copy_cnt_ff, copy_cnt_in;
   logic              pend_ff, pend_in;
   logic [ADDR_W-1:0] dst_ff, dst_in;
   logic [ADDR_W-1:0] blank_ptr_ff, blank_ptr_in;

   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [CELL_W-1:0] mem_wdata;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_raddr;
   cmd_type           rsp_src;

   assign init_busy = (state_ff == BK_INIT);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      copy_cnt_in  = copy_cnt_ff;
      pend_in      = 1'b0;
      dst_in       = dst_ff;
      blank_ptr_in = blank_ptr_ff;
      mem_we       = 1'b0;
      mem_waddr    = blank_ptr_ff;
      mem_wdata    = {cmd_ff.attr, CH_SPACE};
      mem_re       = 1'b0;
      mem_raddr    = cmd.addr;
      cmd_pop      = 1'b0;
      rsp_push     = 1'b0;
      case (state_ff)
         BK_INIT: begin
            mem_we    = 1'b1;
            mem_wdata = RESET_BLANK;
            if (blank_ptr_ff == LastCell) begin
               state_in = BK_IDLE;
            end else begin
               blank_ptr_in = blank_ptr_ff + ADDR_W'(1);
            end
         end
         BK_IDLE: begin
            // room in the result queue is checked up front, so a long
            // command can always deliver its item at the end
            if (!cmd_empty && !rsp_full) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd;
               if (cmd.do_write) begin
                  mem_we    = 1'b1;
                  mem_waddr = cmd.addr;
                  mem_wdata = cmd.wdata;
               end
               if (cmd.do_scroll) begin
                  copy_cnt_in = '0;
                  state_in    = BK_COPY;
               end else if (cmd.do_clear) begin
                  blank_ptr_in = '0;
                  state_in     = BK_BLANK;
               end else if (cmd.do_read) begin
                  mem_re   = cmd.rd_valid;
                  state_in = BK_READ_WAIT;
               end else begin
                  rsp_push = 1'b1;
               end
            end
         end
         BK_READ_WAIT: begin
            rsp_push = 1'b1;
            state_in = BK_IDLE;
         end
         BK_COPY: begin
            // read one row ahead, write the data back in the next cycle
            if (copy_cnt_ff != CopyEnd) begin
               mem_re      = 1'b1;
               mem_raddr   = copy_cnt_ff + ADDR_W'(COLUMNS);
               copy_cnt_in = copy_cnt_ff + ADDR_W'(1);
               pend_in     = 1'b1;
               dst_in      = copy_cnt_ff;
            end
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = dst_ff;
               mem_wdata = rd_data_ff;
            end
            if (copy_cnt_ff == CopyEnd && !pend_ff) begin
               blank_ptr_in = CopyEnd;
               state_in     = BK_BLANK;
            end
         end
         BK_BLANK: begin
            mem_we = 1'b1;
            if (blank_ptr_ff == LastCell) begin
               rsp_push = 1'b1;
               state_in = BK_IDLE;
            end else begin
               blank_ptr_in = blank_ptr_ff + ADDR_W'(1);
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // result comes straight from the queue head for commands done in idle
   always_comb begin
      rsp_src        = (state_ff == BK_IDLE) ? cmd : cmd_ff;
      rsp.row        = rsp_src.row;
      rsp.col        = rsp_src.col;
      rsp.pos        = rsp_src.pos;
      rsp.did_scroll = rsp_src.do_scroll;
      rsp.cell_data  = (state_ff == BK_READ_WAIT && cmd_ff.rd_valid) ? rd_data_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_INIT;
         copy_cnt_ff  <= '0;
         pend_ff      <= 1'b0;
         blank_ptr_ff <= '0;
      end else begin
         state_ff     <= state_in;
         copy_cnt_ff  <= copy_cnt_in;
         pend_ff      <= pend_in;
         blank_ptr_ff <= blank_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      dst_ff <= dst_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cells_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= cells_mem[mem_raddr];
      end
   end

   no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result pushed into a full queue");

   copy_stays_in_upper_rows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_COPY && mem_we) |-> (mem_waddr < CopyEnd))
      else $error("scroll copy wrote into the last row");

   blank_ends_in_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_BLANK && blank_ptr_ff == LastCell) |=> (state_ff == BK_IDLE))
      else $error("blank sweep did not return to idle");

endmodule

### rtl/text_console_cursor_scroll.sv
`timescale 1ns / 1ps

// 80x25 text console: a cell store of attribute/character cells and a cursor.
// Requests enter as a queue: an item is taken when push is high and full is
// low. req_type selects put character, clear screen or read cell. Results
// leave as a queue: the oldest result sits on the rsp_ ports while empty is
// low and is taken when pop is high. Each result carries the cursor after the
// request, a scroll flag and, for reads, the cell.
// csr_wr_en/csr_wr_data set the attribute byte for written and blank cells;
// write it only while no item is in flight.
// A put or an ignored code is answered from the idle state; a read waits in
// the read-wait state for the registered cell. A scroll moves 1920 cells up
// a row (one copy per cycle, the read running one row ahead of the write),
// then blanks the last row; a clear blanks all 2000 cells (one cell written
// per cycle). Puts go through at one item per cycle while the back is idle
// and the result queue has room; reads, scrolls and clears hold the back.
// Reset: the cursor homes, the attribute returns to 0x0F, and a clearing pass
// blanks all 2000 cells of the store while full stays high.
// If pop stays low, the two-entry result queue and the two-entry command queue
// fill and full rises; nothing is lost.

module text_console_cursor_scroll
   import tccs_pkg::*;
#(
   parameter int TAB_WIDTH = DEF_TAB_WIDTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [1:0]        req_type,
   input  logic [CHAR_W-1:0] req_char_code,
   input  logic [ADDR_W-1:0] req_cell_index,
   output logic              empty,
   input  logic              pop,
   output logic [ROW_W-1:0]  rsp_cursor_row,
   output logic [COL_W-1:0]  rsp_cursor_col,
   output logic [ADDR_W-1:0] rsp_cursor_pos,
   output logic              rsp_did_scroll,
   output logic [CELL_W-1:0] rsp_cell_value,
   input  logic              csr_wr_en,
   input  logic [ATTR_W-1:0] csr_wr_data
);

   cmd_type cmd_front;
   cmd_type cmd_back;
   logic    cmd_push;
   logic    cmd_full;
   logic    cmd_pop;
   logic    cmd_empty;
   logic    init_busy;
   rsp_type rsp_back;
   rsp_type rsp_head;
   logic    rsp_push;
   logic    rsp_full;

   tccs_front #(
      .TAB_WIDTH(TAB_WIDTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_type       (req_type),
      .req_char_code  (req_char_code),
      .req_cell_index (req_cell_index),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .init_busy      (init_busy),
      .cmd_full       (cmd_full),
      .cmd_push       (cmd_push),
      .cmd            (cmd_front)
   );

   tccs_fifo #(
      .WIDTH($bits(cmd_type)),
      .DEPTH(CMD_DEPTH)
   ) u_cmd_fifo (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .din   (cmd_front),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .dout  (cmd_back),
      .empty (cmd_empty)
   );

   tccs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd       (cmd_back),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (rsp_back),
      .init_busy (init_busy)
   );

   tccs_fifo #(
      .WIDTH($bits(rsp_type)),
      .DEPTH(RSP_DEPTH)
   ) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .din   (rsp_back),
      .full  (rsp_full),
      .pop   (pop),
      .dout  (rsp_head),
      .empty (empty)
   );

   assign rsp_cursor_row = rsp_head.row;
   assign rsp_cursor_col = rsp_head.col;
   assign rsp_cursor_pos = rsp_head.pos;
   assign rsp_did_scroll = rsp_head.did_scroll;
   assign rsp_cell_value = rsp_head.cell_data;

endmodule
